[rtl/core/bpe_pkg.sv]
// Package for the Bezier point evaluator: field widths, fixed-point constants,
// register index codes and parameter defaults.
// No dependencies.
package bpe_pkg;

   // Parameter defaults
   localparam int MAX_POINTS_DEF = 4;
   localparam int COORD_BITS_DEF = 16;

   // Number of control point registers and axes per point
   localparam int CTRL_REGS = 4;
   localparam int AXES      = 3;

   // Curve parameter, unsigned Q1.16
   localparam int                T_BITS  = 17;
   localparam int                T_SHIFT = 16;
   localparam logic [T_BITS-1:0] T_ONE   = 17'h10000;

   // Point count register
   localparam int                    COUNT_BITS  = 3;
   localparam logic [COUNT_BITS-1:0] COUNT_MIN   = 3'd2;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd4;

   // Register index codes
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POINTS_IN_USE = 3'd0,
      CSR_CTRL_POINT_0  = 3'd1,
      CSR_CTRL_POINT_1  = 3'd2,
      CSR_CTRL_POINT_2  = 3'd3,
      CSR_CTRL_POINT_3  = 3'd4
   } csr_index_type;

endpackage

[rtl/core/bezier_point_evaluator_core.sv]
// Bezier point evaluator core: de Casteljau evaluation of a curve of up to
// MAX_POINTS control points, one lerp level per two pipeline stages.
// Depends on bpe_pkg.
//
// Usage
//  - Configuration: write points_in_use (index 0) and ctrl_point_0..3
//    (index 1..4) over the csr_ channel; csr_ready is always high. Each
//    point packs {z,y,x} as signed Q8.8. Write only while no transaction
//    is in flight; other indexes are ignored.
//  - Input: a transaction is taken at each rising edge with start high and
//    busy low. busy never rises, so a new curve_param t (Q1.16, values
//    above 1.0 clip to 1.0) can enter in every cycle.
//  - Output: rsp_strobe marks each result for exactly one cycle, once it has
//    passed stage 0 and every multiply and shift-and-add stage. Results
//    come out in input order, one per input; the receiver cannot stall.
//  - Rate: one transaction per cycle. Each lerp level is a multiply stage
//    ((p1 - p0) * t) followed by a shift-and-add stage, and every stage
//    advances every cycle.
//  - Point counts below MAX_POINTS bypass the leading levels, so latency is
//    the same for every count.
//  - Reset (synchronous, active high): drop all transactions in flight,
//    points_in_use returns to 4 and all control points to zero.
module bezier_point_evaluator_core #(
   parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel
   input  logic                                start,
   output logic                                busy,
   input  logic [bpe_pkg::T_BITS-1:0]          req_curve_param,
   // Result channel
   output logic                                rsp_strobe,
   output logic signed [COORD_BITS-1:0]        rsp_point_x,
   output logic signed [COORD_BITS-1:0]        rsp_point_y,
   output logic signed [COORD_BITS-1:0]        rsp_point_z,
   // Configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [3*COORD_BITS-1:0]             csr_wdata
);

   localparam int LEVELS = MAX_POINTS - 1;
   localparam int AXES   = bpe_pkg::AXES;
   localparam int TB     = bpe_pkg::T_BITS;
   localparam int PROD_W = COORD_BITS + TB + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // Configuration registers
   logic [bpe_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [3*COORD_BITS-1:0]        ctrl_ff [bpe_pkg::CTRL_REGS];
   logic [3*COORD_BITS-1:0]        ctrl_in [bpe_pkg::CTRL_REGS];

   // Pipeline valid bits: vb_* after each point stage, va_* after each multiply
   logic [LEVELS:0]   vb_ff, vb_in;
   logic [LEVELS-1:0] va_ff, va_in;

   // Point stages (stage 0 holds the unpacked control points)
   coord_type pt_ff [LEVELS+1][MAX_POINTS][AXES];
   coord_type pt_in [LEVELS+1][MAX_POINTS][AXES];
   logic [TB-1:0]     t_ff   [LEVELS];
   logic [TB-1:0]     t_in   [LEVELS];
   logic [LEVELS-1:0] act_ff [LEVELS];
   logic [LEVELS-1:0] act_in [LEVELS];

   // Multiply stages
   logic signed [PROD_W-1:0] prod_ff [LEVELS][MAX_POINTS][AXES];
   logic signed [PROD_W-1:0] prod_in [LEVELS][MAX_POINTS][AXES];
   coord_type                base_ff [LEVELS][MAX_POINTS][AXES];
   coord_type                base_in [LEVELS][MAX_POINTS][AXES];
   logic [TB-1:0]            ta_ff   [LEVELS];
   logic [TB-1:0]            ta_in   [LEVELS];
   logic [LEVELS-1:0]        acta_ff [LEVELS];
   logic [LEVELS-1:0]        acta_in [LEVELS];

   logic accept;

   // The pipeline never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Register writes
   always_comb begin
      count_in = count_ff;
      ctrl_in  = ctrl_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpe_pkg::CSR_POINTS_IN_USE: count_in = csr_wdata[bpe_pkg::COUNT_BITS-1:0];
            bpe_pkg::CSR_CTRL_POINT_0:  ctrl_in[0] = csr_wdata;
            bpe_pkg::CSR_CTRL_POINT_1:  ctrl_in[1] = csr_wdata;
            bpe_pkg::CSR_CTRL_POINT_2:  ctrl_in[2] = csr_wdata;
            bpe_pkg::CSR_CTRL_POINT_3:  ctrl_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   // Datapath next values
   always_comb begin
      logic [bpe_pkg::COUNT_BITS-1:0] n_clamp;
      logic signed [COORD_BITS:0]     diff;
      logic signed [TB:0]             ts;
      logic signed [PROD_W-1:0]       q;
      logic signed [PROD_W-1:0]       sum;

      // Stage 0: clip the point count and t, unpack the control points
      n_clamp = count_ff;
      if (count_ff < bpe_pkg::COUNT_MIN) begin
         n_clamp = bpe_pkg::COUNT_MIN;
      end else if (int'(count_ff) > MAX_POINTS) begin
         n_clamp = bpe_pkg::COUNT_BITS'(MAX_POINTS);
      end

      t_in[0] = (req_curve_param > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : req_curve_param;

      // Level lv runs only once the point count has shrunk to the count in use
      for (int lv = 0; lv < LEVELS; lv++) begin
         act_in[0][lv] = (lv + int'(n_clamp)) >= MAX_POINTS;
      end

      for (int i = 0; i < MAX_POINTS; i++) begin
         for (int a = 0; a < AXES; a++) begin
            pt_in[0][i][a] = ctrl_ff[i][a*COORD_BITS +: COORD_BITS];
         end
      end

      // Multiply stages: (p1 - p0) * t
      for (int lv = 0; lv < LEVELS; lv++) begin
         ta_in[lv]   = t_ff[lv];
         acta_in[lv] = act_ff[lv];
         for (int a = 0; a < AXES; a++) begin
            for (int i = 0; i < MAX_POINTS; i++) begin
               base_in[lv][i][a] = pt_ff[lv][i][a];
            end
            prod_in[lv][MAX_POINTS-1][a] = '0;
            for (int i = 0; i < MAX_POINTS-1; i++) begin
               diff = (COORD_BITS+1)'(pt_ff[lv][i+1][a]) - (COORD_BITS+1)'(pt_ff[lv][i][a]);
               ts   = $signed({1'b0, t_ff[lv]});
               prod_in[lv][i][a] = diff * ts;
            end
         end
      end

      // Shift-and-add stages: p0 + floor(prod / 2^16), or hold p0 when bypassed
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (lv + 1 < LEVELS) begin
            t_in[lv+1]   = ta_ff[lv];
            act_in[lv+1] = acta_ff[lv];
         end
         for (int i = 0; i < MAX_POINTS; i++) begin
            for (int a = 0; a < AXES; a++) begin
               q   = prod_ff[lv][i][a] >>> bpe_pkg::T_SHIFT;
               sum = PROD_W'(base_ff[lv][i][a]) + q;
               pt_in[lv+1][i][a] = acta_ff[lv][lv] ? sum[COORD_BITS-1:0] : base_ff[lv][i][a];
            end
         end
      end
   end

   // Valid bits advance one stage per cycle
   always_comb begin
      vb_in[0] = accept;
      for (int lv = 0; lv < LEVELS; lv++) begin
         va_in[lv]   = vb_ff[lv];
         vb_in[lv+1] = va_ff[lv];
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff    <= '0;
         va_ff    <= '0;
         count_ff <= bpe_pkg::COUNT_RESET;
         for (int r = 0; r < bpe_pkg::CTRL_REGS; r++) begin
            ctrl_ff[r] <= '0;
         end
      end else begin
         vb_ff    <= vb_in;
         va_ff    <= va_in;
         count_ff <= count_in;
         ctrl_ff  <= ctrl_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pt_ff   <= pt_in;
      t_ff    <= t_in;
      act_ff  <= act_in;
      prod_ff <= prod_in;
      base_ff <= base_in;
      ta_ff   <= ta_in;
      acta_ff <= acta_in;
   end

   // The last point stage is the output register
   assign rsp_strobe  = vb_ff[LEVELS];
   assign rsp_point_x = pt_ff[LEVELS][0][0];
   assign rsp_point_y = pt_ff[LEVELS][0][1];
   assign rsp_point_z = pt_ff[LEVELS][0][2];

endmodule

[tb/bezier_point_evaluator_checker.sv]
// Checker for the Bezier point evaluator: tracks register writes, predicts each curve
// point by de Casteljau interpolation and compares it with the result port.
// Depends on bpe_pkg.
`timescale 1ns / 100ps

module bezier_point_evaluator_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic                                      busy,
   input  logic [bpe_pkg::T_BITS-1:0]                req_curve_param,
   input  logic                                      rsp_strobe,
   input  logic signed [bpe_pkg::COORD_BITS_DEF-1:0] rsp_point_x,
   input  logic signed [bpe_pkg::COORD_BITS_DEF-1:0] rsp_point_y,
   input  logic signed [bpe_pkg::COORD_BITS_DEF-1:0] rsp_point_z,
   input  logic                                      csr_valid,
   input  logic                                      csr_ready,
   input  logic [bpe_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [3*bpe_pkg::COORD_BITS_DEF-1:0]      csr_wdata,
   output int                                        mismatch_count,
   output int                                        results_outstanding
);

   localparam int CB            = bpe_pkg::COORD_BITS_DEF;
   localparam int REPORT_LIMIT  = 10;
   localparam int CTRL_IDX_BITS = $clog2(bpe_pkg::CTRL_REGS);

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } curve_point_type;

   logic [bpe_pkg::COUNT_BITS-1:0] point_count_reg = bpe_pkg::COUNT_RESET;
   logic [3*CB-1:0]                ctrl_reg [bpe_pkg::CTRL_REGS];
   curve_point_type                expected_points [$];
   int                             failures = 0;

   // Reduce the control points in use level by level down to one point.
   function automatic curve_point_type evaluate_curve(logic [bpe_pkg::T_BITS-1:0] t_raw);
      longint          pts [bpe_pkg::CTRL_REGS][bpe_pkg::AXES];
      longint          t;
      int              n;
      coord_type       c;
      curve_point_type p;
      n = int'(point_count_reg);
      if (n < int'(bpe_pkg::COUNT_MIN)) n = int'(bpe_pkg::COUNT_MIN);
      if (n > bpe_pkg::MAX_POINTS_DEF) n = bpe_pkg::MAX_POINTS_DEF;
      t = longint'((t_raw > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : t_raw);
      for (int i = 0; i < bpe_pkg::CTRL_REGS; i++) begin
         for (int a = 0; a < bpe_pkg::AXES; a++) begin
            c = ctrl_reg[i][a*CB +: CB];
            pts[i][a] = longint'(c);
         end
      end
      for (int lvl = n; lvl > 1; lvl--) begin
         for (int i = 0; i < lvl - 1; i++) begin
            for (int a = 0; a < bpe_pkg::AXES; a++) begin
               // arithmetic shift: round toward minus infinity
               pts[i][a] = pts[i][a] + (((pts[i+1][a] - pts[i][a]) * t) >>> bpe_pkg::T_SHIFT);
            end
         end
      end
      p.x = coord_type'(pts[0][0]);
      p.y = coord_type'(pts[0][1]);
      p.z = coord_type'(pts[0][2]);
      return p;
   endfunction

   always @(posedge clock) begin
      curve_point_type observed;
      curve_point_type wanted;
      if (reset) begin
         point_count_reg = bpe_pkg::COUNT_RESET;
         for (int i = 0; i < bpe_pkg::CTRL_REGS; i++) ctrl_reg[i] = '0;
         expected_points.delete();
      end else begin
         if (rsp_strobe) begin
            observed.x = rsp_point_x;
            observed.y = rsp_point_y;
            observed.z = rsp_point_z;
            if (expected_points.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: unexpected curve point x=%h y=%h z=%h",
                           $time, observed.x, observed.y, observed.z);
            end else begin
               wanted = expected_points.pop_front();
               if (observed.x != wanted.x || observed.y != wanted.y ||
                   observed.z != wanted.z) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display({"%0t: curve point mismatch: expected x=%h y=%h z=%h, ",
                               "got x=%h y=%h z=%h"},
                              $time, wanted.x, wanted.y, wanted.z,
                              observed.x, observed.y, observed.z);
               end
            end
         end
         // predict with the registers as they stood before this edge
         if (start && !busy)
            expected_points.insert(expected_points.size(), evaluate_curve(req_curve_param));
         if (csr_valid && csr_ready) begin
            unique case (csr_index) inside
               bpe_pkg::CSR_POINTS_IN_USE:
                  point_count_reg = csr_wdata[bpe_pkg::COUNT_BITS-1:0];
               bpe_pkg::CSR_CTRL_POINT_0, bpe_pkg::CSR_CTRL_POINT_1,
               bpe_pkg::CSR_CTRL_POINT_2, bpe_pkg::CSR_CTRL_POINT_3:
                  ctrl_reg[CTRL_IDX_BITS'(csr_index - bpe_pkg::CSR_CTRL_POINT_0)] = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatch_count      <= failures;
      results_outstanding <= expected_points.size();
   end

endmodule

[tb/bezier_point_evaluator_core_test.sv]
// Top level of the Bezier point evaluator testbench: clock, reset, register writes and
// curve parameter stimulus, plus the final verdict.
// Depends on bpe_pkg, bezier_point_evaluator_core and bezier_point_evaluator_checker.
`timescale 1ns / 100ps

module bezier_point_evaluator_core_test;

   localparam int CB              = bpe_pkg::COORD_BITS_DEF;
   localparam int TB              = bpe_pkg::T_BITS;
   localparam int IB              = bpe_pkg::CSR_INDEX_BITS;
   localparam int PIPE_LATENCY    = 2 * (bpe_pkg::MAX_POINTS_DEF - 1);
   localparam int SETTLE_CYCLES   = 4 * PIPE_LATENCY;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int IDLE_PCT        = 10;
   localparam int RANDOM_PHASES   = 10;
   localparam int QUIET_PHASE     = 3;
   localparam int ITEMS_PER_PHASE = 85;

   // indexes that decode to no register
   localparam logic [IB-1:0] CSR_UNMAPPED_LO = 3'd5;
   localparam logic [IB-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam logic [CB-1:0] COORD_MIN = 16'h8000;
   localparam logic [CB-1:0] COORD_MAX = 16'h7FFF;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [TB-1:0]               req_curve_param = '0;
   logic                        rsp_strobe;
   logic signed [CB-1:0]        rsp_point_x;
   logic signed [CB-1:0]        rsp_point_y;
   logic signed [CB-1:0]        rsp_point_z;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [IB-1:0]               csr_index = bpe_pkg::CSR_POINTS_IN_USE;
   logic [3*CB-1:0]             csr_wdata = '0;

   int                          mismatch_count;
   int                          results_outstanding;
   int                          cycle_count = 0;
   int                          idle_pct = IDLE_PCT;

   // control points staged for the next configuration
   logic [3*CB-1:0]             curve_ctrl [bpe_pkg::CTRL_REGS];

   // t at and around zero, one half and one, plus the saturating values
   logic [TB-1:0] corner_params [8] = '{
      17'h00000, 17'h00001, 17'h08000, 17'h0FFFF,
      17'h10000, 17'h10001, 17'h1FFFF, 17'h15555
   };

   bezier_point_evaluator_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_curve_param (req_curve_param),
      .rsp_strobe      (rsp_strobe),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   bezier_point_evaluator_checker scoreboard (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_curve_param     (req_curve_param),
      .rsp_strobe          (rsp_strobe),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_point_z         (rsp_point_z),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Abort a hung run: count cycles and fail past the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Pick a coordinate, biased toward the two extremes of Q8.8.
   function automatic logic [CB-1:0] pick_coord();
      case ($urandom_range(3))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         default: return CB'($urandom);
      endcase
   endfunction

   // Pick t: mostly inside 0..1.0, sometimes exactly at an end, sometimes above 1.0.
   function automatic logic [TB-1:0] random_param();
      case ($urandom_range(19))
         0:       return '0;
         1:       return bpe_pkg::T_ONE;
         2, 3:    return TB'($urandom_range(2**TB - 1, bpe_pkg::T_ONE + 1));
         default: return TB'($urandom_range(bpe_pkg::T_ONE));
      endcase
   endfunction

   // Build a point count word: noise in the upper bits, a count in the low bits,
   // mostly legal, now and then one that must be clamped.
   function automatic logic [3*CB-1:0] random_count_word();
      logic [3*CB-1:0] w;
      w = (3*CB)'({$urandom, $urandom});
      if ($urandom_range(3) == 0)
         w[bpe_pkg::COUNT_BITS-1:0] = bpe_pkg::COUNT_BITS'($urandom_range(7));
      else
         w[bpe_pkg::COUNT_BITS-1:0] = bpe_pkg::COUNT_BITS'(
            $urandom_range(bpe_pkg::MAX_POINTS_DEF, bpe_pkg::COUNT_MIN));
      return w;
   endfunction

   // Present one register write and hold it until the handshake completes.
   // Leave csr_valid high so back-to-back writes run without csr_valid dropping in between.
   task automatic write_csr(logic [IB-1:0] idx, logic [3*CB-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Load the point count and all staged control points; optionally poke an
   // unmapped index, which must leave every register untouched.
   task automatic configure_curve(logic [3*CB-1:0] count_word, bit poke_unmapped);
      write_csr(bpe_pkg::CSR_POINTS_IN_USE, count_word);
      for (int i = 0; i < bpe_pkg::CTRL_REGS; i++)
         write_csr(IB'(int'(bpe_pkg::CSR_CTRL_POINT_0) + i), curve_ctrl[i]);
      if (poke_unmapped)
         write_csr(IB'($urandom_range(CSR_UNMAPPED_HI, CSR_UNMAPPED_LO)),
                   (3*CB)'({$urandom, $urandom}));
      csr_valid <= 1'b0;
   endtask

   // Send one curve parameter, first idling for a random number of cycles.
   // Drive junk on the parameter while idle; it must never be taken.
   task automatic send_param(logic [TB-1:0] t);
      while ($urandom_range(99) < idle_pct) begin
         start           <= 1'b0;
         req_curve_param <= TB'($urandom_range(2**TB - 1));
         @(posedge clock);
      end
      start           <= 1'b1;
      req_curve_param <= t;
      do @(posedge clock); while (busy);
   endtask

   // Hold off the sender until every predicted point has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset state: four points, all at the origin.
      send_param(bpe_pkg::T_ONE >> 1);
      send_param(bpe_pkg::T_ONE);
      wait_drained();

      // Alternate extremes between neighbors so every difference is full scale.
      curve_ctrl[0] = {COORD_MIN, COORD_MAX, COORD_MIN};
      curve_ctrl[1] = {COORD_MAX, COORD_MIN, COORD_MAX};
      curve_ctrl[2] = {COORD_MIN, COORD_MAX, COORD_MIN};
      curve_ctrl[3] = {COORD_MAX, COORD_MIN, COORD_MAX};
      configure_curve((3*CB)'(bpe_pkg::MAX_POINTS_DEF), 1'b0);
      foreach (corner_params[i]) send_param(corner_params[i]);
      wait_drained();

      // Walk every point count but four, clamped ones below two and above four included.
      for (int c = 0; c < 2**bpe_pkg::COUNT_BITS; c++) begin
         if (c == bpe_pkg::MAX_POINTS_DEF) continue;
         configure_curve((3*CB)'(c), 1'b1);
         send_param(bpe_pkg::T_ONE);
         send_param(TB'($urandom_range(bpe_pkg::T_ONE)));
         wait_drained();
      end

      // Random phases: fresh curve each time, a drain between phases,
      // and one phase with no idling at all.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;
         for (int i = 0; i < bpe_pkg::CTRL_REGS; i++)
            curve_ctrl[i] = {pick_coord(), pick_coord(), pick_coord()};
         configure_curve(random_count_word(), $urandom_range(3) == 0);
         repeat (ITEMS_PER_PHASE) send_param(random_param());
         wait_drained();
      end

      // Let any stray strobe show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
